### rtl/stnh_pkg.sv
// Package for the segment/triangle nearest-hit block: widths, states and
// shared types. No dependencies.
package stnh_pkg;

   localparam int CoordWidth = 32;
   localparam int WideWidth  = 256;
   localparam int CsrIdxWidth = 3;
   localparam int CsrDataWidth = 40;

   localparam logic [CsrIdxWidth-1:0] CSR_START_X = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_START_Y = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_START_Z = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_END_X   = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_END_Y   = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CSR_END_Z   = 3'd5;
   localparam logic [CsrIdxWidth-1:0] CSR_PAR_TOL = 3'd6;
   localparam logic [CsrIdxWidth-1:0] CSR_T_TOL   = 3'd7;

   localparam logic [39:0] ParTolReset = 40'd281474977;
   localparam logic [29:0] TTolReset   = 30'd1074;

   typedef logic signed [WideWidth-1:0] wide_type;

   // Multiplier request/response between sequencer and shared unit.
   typedef struct packed {
      logic     start;
      wide_type a;
      wide_type b;
   } mul_req_type;

   typedef struct packed {
      logic     done;
      wide_type p;
   } mul_rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_EDGE, ST_NORM, ST_DOT, ST_SIGN, ST_BOUND, ST_DIV, ST_PT,
      ST_BARY, ST_DEN, ST_UV, ST_DECIDE, ST_OUT
   } state_type;

endpackage

### rtl/stnh_if.sv
// Valid/ready channel interfaces for the nearest-hit block.
// Depends on stnh_pkg.
interface stnh_req_if import stnh_pkg::*; ();
   logic valid;
   logic ready;
   logic signed [CoordWidth-1:0] vertex_a_x, vertex_a_y, vertex_a_z;
   logic signed [CoordWidth-1:0] vertex_b_x, vertex_b_y, vertex_b_z;
   logic signed [CoordWidth-1:0] vertex_c_x, vertex_c_y, vertex_c_z;
   logic last_triangle;
   modport source (output valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x,
      vertex_b_y, vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z, last_triangle,
      input ready);
   modport sink (input valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x,
      vertex_b_y, vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z, last_triangle,
      output ready);
endinterface

interface stnh_rsp_if import stnh_pkg::*; ();
   logic valid;
   logic ready;
   logic hit_found;
   logic signed [CoordWidth-1:0] hit_x, hit_y, hit_z;
   modport source (output valid, hit_found, hit_x, hit_y, hit_z, input ready);
   modport sink (input valid, hit_found, hit_x, hit_y, hit_z, output ready);
endinterface

interface stnh_csr_if import stnh_pkg::*; ();
   logic valid;
   logic ready;
   logic [CsrIdxWidth-1:0]  index;
   logic [CsrDataWidth-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### rtl/segment_triangle_nearest_hit.sv
// Each product on the one shared multiplier is formed from 36 32x32 partial
// products, one a cycle; req.ready is low while a triangle is worked on. A
// parallel triangle needs 12 products, one with t out of range 14, one that
// reaches the inside test 38 products and a 32-step restoring division. After
// the last triangle one result beat is held until taken. Synchronous
// active-high reset.
module segment_triangle_nearest_hit import stnh_pkg::*; #(
   parameter int PARAM_FRACTION_BITS = 30
) (
   input logic clock,
   input logic reset,
   stnh_req_if.sink   req,
   stnh_rsp_if.source rsp,
   stnh_csr_if.sink   csr
);
   mul_req_type mreq;
   mul_rsp_type mrsp;

   // Sequencer and the shared multiplier it drives.
   stnh_seq #(.PARAM_FRACTION_BITS(PARAM_FRACTION_BITS)) u_seq (
      .clock, .reset, .req, .rsp, .csr, .mreq, .mrsp);
   stnh_mul u_mul (.clock, .reset, .req(mreq), .rsp(mrsp));
endmodule

### rtl/stnh_mul.sv
// Shared signed multiplier: 256-bit operands, product mod 2^256, formed
// 32x32 bits a cycle. Depends on stnh_pkg.
module stnh_mul import stnh_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type req,
   output mul_rsp_type rsp
);
   localparam int Limbs = WideWidth / 32;

   logic [WideWidth-1:0] a_ff, a_in, b_ff, b_in, acc_ff, acc_in;
   logic [2:0] i_ff, i_in, j_ff, j_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [31:0] al, bl;
   logic [63:0] pp_ff, pp_in;
   logic pv_ff, pv_in;
   logic [8:0] sh_ff, sh_in;
   logic last_ff, last_in;

   // One partial product a cycle, accumulated from its register in the next cycle.
   always_comb begin
      a_in = a_ff; b_in = b_ff; acc_in = acc_ff; i_in = i_ff; j_in = j_ff;
      busy_in = busy_ff; done_in = 1'b0; pv_in = 1'b0; last_in = 1'b0;
      sh_in = sh_ff;
      al = a_ff[32*i_ff +: 32];
      bl = b_ff[32*j_ff +: 32];
      pp_in = al * bl;
      if (pv_ff) begin
         acc_in = acc_ff + ({192'd0, pp_ff} << sh_ff);
         done_in = last_ff;
      end
      if (req.start) begin
         a_in = req.a; b_in = req.b; acc_in = '0;
         i_in = '0; j_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         pv_in = 1'b1;
         sh_in = 9'(32 * (int'(i_ff) + int'(j_ff)));
         if (32'(i_ff) + 32'(j_ff) == Limbs - 1) begin
            j_in = '0;
            if (32'(i_ff) == Limbs - 1) begin
               busy_in = 1'b0; last_in = 1'b1;
            end else begin
               i_in = i_ff + 3'd1;
            end
         end else begin
            j_in = j_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in; b_ff <= b_in; acc_ff <= acc_in; i_ff <= i_in; j_ff <= j_in;
      pp_ff <= pp_in; sh_ff <= sh_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; pv_ff <= 1'b0; last_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; pv_ff <= pv_in;
         last_ff <= last_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.p    = acc_ff;
endmodule

### rtl/stnh_seq.sv
// Sequencer for one triangle: drives the shared multiplier, does the
// restoring division bit by bit and keeps the best hit. Depends on stnh_pkg.
module stnh_seq import stnh_pkg::*; #(
   parameter int PARAM_FRACTION_BITS = 30
) (
   input  logic clock,
   input  logic reset,
   stnh_req_if.sink   req,
   stnh_rsp_if.source rsp,
   stnh_csr_if.sink   csr,
   output mul_req_type mreq,
   input  mul_rsp_type mrsp
);
   localparam int PF = PARAM_FRACTION_BITS;

   state_type st_ff, st_in;
   logic [4:0] k_ff, k_in;
   logic go_ff, go_in;
   wide_type w_ff[16];
   wide_type w_in[16];
   logic signed [32:0] v_ff[9];
   logic signed [32:0] s_ff[6];
   logic [39:0] ptol_ff;
   logic [29:0] ttol_ff;
   logic last_ff, any_ff, any_in, hit_ok_ff, hit_ok_in;
   logic [31:0] best_ff, best_in, tq_ff, tq_in;
   logic signed [31:0] bp_ff[3];
   logic signed [31:0] bp_in[3];
   logic signed [31:0] p_ff[3];
   logic signed [31:0] p_in[3];
   logic rv_ff, rv_in, rhit_ff, rhit_in;
   logic signed [31:0] rx_ff, rx_in, ry_ff, ry_in, rz_ff, rz_in;
   wide_type ma, mb, rem, ds, diff;
   wide_type r64;
   logic accept;
   logic [1:0] pr, pk, ba;
   logic [2:0] bt;
   logic [4:0] bsel;

   function automatic wide_type wx(input logic signed [32:0] x);
      return wide_type'(x);
   endfunction

   function automatic logic signed [31:0] sat(input wide_type x);
      if (x > wide_type'(64'sd2147483647)) return 32'sh7fffffff;
      if (x < wide_type'(-64'sd2147483648)) return 32'sh80000000;
      return x[31:0];
   endfunction

   // Barycentric step k split into term and axis, k = 3*term + axis.
   function automatic logic [4:0] bary_sel(input logic [4:0] k);
      logic [2:0] term;
      logic [4:0] base;
      priority if (k >= 5'd12) begin term = 3'd4; base = 5'd12; end
      else if (k >= 5'd9) begin term = 3'd3; base = 5'd9; end
      else if (k >= 5'd6) begin term = 3'd2; base = 5'd6; end
      else if (k >= 5'd3) begin term = 3'd1; base = 5'd3; end
      else begin term = 3'd0; base = 5'd0; end
      return {term, 2'(k - base)};
   endfunction

   assign accept    = req.valid && req.ready;
   assign req.ready = (st_ff == ST_IDLE) && !rv_ff;
   assign csr.ready = 1'b1;

   // Registers are held here: w[0..2] e0, w[3..5] e1, w[6..8] n and later den, u, v, w[9] d,
   // w[10] num, w[11..15] scratch (dot sums and barycentric terms).
   always_comb begin
      st_in = st_ff; k_in = k_ff; go_in = 1'b0; any_in = any_ff;
      best_in = best_ff; tq_in = tq_ff; hit_ok_in = hit_ok_ff;
      rv_in = rv_ff; rhit_in = rhit_ff; rx_in = rx_ff; ry_in = ry_ff; rz_in = rz_ff;
      for (int i = 0; i < 16; i++) w_in[i] = w_ff[i];
      for (int i = 0; i < 3; i++) begin bp_in[i] = bp_ff[i]; p_in[i] = p_ff[i]; end
      ma = '0; mb = '0;
      rem = w_ff[10]; ds = w_ff[9] <<< k_ff; diff = rem - ds;
      r64 = '0;
      pr = k_ff[2:1]; pk = k_ff[1:0];
      bsel = bary_sel(k_ff); bt = bsel[4:2]; ba = bsel[1:0];
      if (rv_ff && rsp.ready) rv_in = 1'b0;
      unique case (st_ff)
         ST_IDLE: if (accept) begin st_in = ST_EDGE; k_in = '0; end
         ST_EDGE: begin
            for (int i = 0; i < 3; i++) begin
               w_in[i]   = wx(v_ff[3+i]) - wx(v_ff[i]);
               w_in[3+i] = wx(v_ff[6+i]) - wx(v_ff[i]);
            end
            for (int i = 6; i < 16; i++) w_in[i] = '0;
            st_in = ST_NORM; k_in = '0; go_in = 1'b1;
         end
         // Six products of the cross product; k picks the term.
         ST_NORM: begin
            unique case (k_ff[2:0])
               3'd0: begin ma = w_ff[1]; mb = w_ff[5]; end
               3'd1: begin ma = w_ff[2]; mb = w_ff[4]; end
               3'd2: begin ma = w_ff[2]; mb = w_ff[3]; end
               3'd3: begin ma = w_ff[0]; mb = w_ff[5]; end
               3'd4: begin ma = w_ff[0]; mb = w_ff[4]; end
               default: begin ma = w_ff[1]; mb = w_ff[3]; end
            endcase
            if (mrsp.done) begin
               if (k_ff[0]) w_in[4'd6 + {2'b00, pr}] = w_ff[4'd6 + {2'b00, pr}] - mrsp.p;
               else         w_in[4'd6 + {2'b00, pr}] = w_ff[4'd6 + {2'b00, pr}] + mrsp.p;
               if (k_ff == 5'd5) begin st_in = ST_DOT; k_in = '0; end
               else k_in = k_ff + 5'd1;
               go_in = 1'b1;
            end
         end
         // d and num: even k for dir.n, odd k for (A-start).n.
         ST_DOT: begin
            ma = k_ff[0] ? wx(v_ff[{2'b00, pr}]) - wx(s_ff[{1'b0, pr}])
                         : wx(s_ff[3'd3 + {1'b0, pr}]) - wx(s_ff[{1'b0, pr}]);
            mb = w_ff[4'd6 + {2'b00, pr}];
            if (mrsp.done) begin
               if (k_ff[0]) w_in[10] = w_ff[10] + mrsp.p;
               else         w_in[9]  = w_ff[9] + mrsp.p;
               if (k_ff == 5'd5) st_in = ST_SIGN;
               else begin k_in = k_ff + 5'd1; go_in = 1'b1; end
            end
         end
         ST_SIGN: begin
            if (w_ff[9] < 0) begin w_in[9] = -w_ff[9]; w_in[10] = -w_ff[10]; end
            w_in[10] = (w_ff[9] < 0 ? -w_ff[10] : w_ff[10]) <<< PF;
            if (w_ff[9] == 0 || (w_ff[9] < 0 ? -w_ff[9] : w_ff[9]) <
                  wide_type'({1'b0, ptol_ff}))
               st_in = ST_DECIDE;
            else begin st_in = ST_BOUND; k_in = '0; go_in = 1'b1; end
            hit_ok_in = 1'b0;
         end
         // Bounds: k0 lo = ttol*d, k1 hi = (2^PF+ttol+1)*d.
         ST_BOUND: begin
            ma = k_ff[0] ? wide_type'((64'd1 << PF) + 64'(ttol_ff) + 64'd1)
                         : wide_type'({1'b0, ttol_ff});
            mb = w_ff[9];
            if (mrsp.done) begin
               if (!k_ff[0]) begin
                  hit_ok_in = !(w_ff[10] < mrsp.p);
                  k_in = 5'd1; go_in = 1'b1;
               end else begin
                  if (hit_ok_ff && w_ff[10] < mrsp.p) begin
                     st_in = ST_DIV; k_in = 5'd31; tq_in = '0;
                  end else st_in = ST_DECIDE;
                  hit_ok_in = 1'b0;
               end
            end
         end
         ST_DIV: begin
            if (!(rem < ds)) begin w_in[10] = diff; tq_in[k_ff] = 1'b1; end
            if (k_ff == 5'd0) begin st_in = ST_PT; k_in = '0; go_in = 1'b1; end
            else k_in = k_ff - 5'd1;
         end
         // Hit point per axis, rounded half up, saturated.
         ST_PT: begin
            ma = wide_type'({1'b0, tq_ff});
            mb = wx(s_ff[3'd3 + {1'b0, pk}]) - wx(s_ff[{1'b0, pk}]);
            if (mrsp.done) begin
               r64 = (mrsp.p + (wide_type'(1) <<< (PF-1))) >>> PF;
               p_in[pk] = sat(wx(s_ff[{1'b0, pk}]) + r64);
               if (k_ff == 5'd2) begin
                  st_in = ST_BARY; k_in = '0;
                  for (int i = 11; i < 16; i++) w_in[i] = '0;
               end else k_in = k_ff + 5'd1;
               go_in = 1'b1;
            end
         end
         // Five dot sums over three axes: k = 3*term + axis.
         ST_BARY: begin
            unique case (bt)
               3'd0: begin ma = w_ff[{2'b00, ba}]; mb = w_ff[{2'b00, ba}]; end
               3'd1: begin ma = w_ff[{2'b00, ba}]; mb = w_ff[4'd3 + {2'b00, ba}]; end
               3'd2: begin ma = w_ff[{2'b00, ba}];
                  mb = wx({p_ff[ba][31], p_ff[ba]}) - wx(v_ff[{2'b00, ba}]); end
               3'd3: begin ma = w_ff[4'd3 + {2'b00, ba}]; mb = ma; end
               default: begin ma = w_ff[4'd3 + {2'b00, ba}];
                  mb = wx({p_ff[ba][31], p_ff[ba]}) - wx(v_ff[{2'b00, ba}]); end
            endcase
            if (mrsp.done) begin
               w_in[4'd11 + {1'b0, bt}] = w_ff[4'd11 + {1'b0, bt}] + mrsp.p;
               if (k_ff == 5'd14) begin
                  st_in = ST_DEN; k_in = '0;
                  w_in[6] = '0; w_in[7] = '0; w_in[8] = '0;
               end else k_in = k_ff + 5'd1;
               go_in = 1'b1;
            end
         end
         // den, u, v: two products each; w11=d00 w12=d01 w13=d02 w14=d11 w15=d12.
         ST_DEN: begin
            unique case (k_ff[2:0])
               3'd0: begin ma = w_ff[11]; mb = w_ff[14]; end
               3'd1: begin ma = w_ff[12]; mb = w_ff[12]; end
               3'd2: begin ma = w_ff[14]; mb = w_ff[13]; end
               3'd3: begin ma = w_ff[12]; mb = w_ff[15]; end
               3'd4: begin ma = w_ff[11]; mb = w_ff[15]; end
               default: begin ma = w_ff[12]; mb = w_ff[13]; end
            endcase
            if (mrsp.done) begin
               if (k_ff[0]) w_in[4'd6 + {2'b00, pr}] = w_ff[4'd6 + {2'b00, pr}] - mrsp.p;
               else         w_in[4'd6 + {2'b00, pr}] = w_ff[4'd6 + {2'b00, pr}] + mrsp.p;
               if (k_ff == 5'd5) st_in = ST_UV;
               else begin k_in = k_ff + 5'd1; go_in = 1'b1; end
            end
         end
         ST_UV: begin
            hit_ok_in = (w_ff[6] > 0) && !(w_ff[7] < 0) && !(w_ff[8] < 0)
                        && !(w_ff[6] < w_ff[7] + w_ff[8]) && (tq_ff < best_ff);
            st_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (hit_ok_ff) begin
               any_in = 1'b1; best_in = tq_ff;
               for (int i = 0; i < 3; i++) bp_in[i] = p_ff[i];
            end
            st_in = last_ff ? ST_OUT : ST_IDLE;
         end
         ST_OUT: begin
            if (!rv_ff) begin
               rv_in = 1'b1; rhit_in = any_ff;
               rx_in = any_ff ? bp_ff[0] : '0;
               ry_in = any_ff ? bp_ff[1] : '0;
               rz_in = any_ff ? bp_ff[2] : '0;
               any_in = 1'b0; best_in = '1;
               for (int i = 0; i < 3; i++) bp_in[i] = '0;
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   assign mreq.start = go_ff;
   assign mreq.a = ma;
   assign mreq.b = mb;

   // Operands are latched by the multiplier on start, so they are driven from
   // the sequencer's registered state in the cycle after the step advances.
   always_ff @(posedge clock) begin
      for (int i = 0; i < 16; i++) w_ff[i] <= w_in[i];
      tq_ff <= tq_in;
      for (int i = 0; i < 3; i++) p_ff[i] <= p_in[i];
      rx_ff <= rx_in; ry_ff <= ry_in; rz_ff <= rz_in; rhit_ff <= rhit_in;
      if (accept) begin
         v_ff[0] <= 33'(req.vertex_a_x); v_ff[1] <= 33'(req.vertex_a_y);
         v_ff[2] <= 33'(req.vertex_a_z); v_ff[3] <= 33'(req.vertex_b_x);
         v_ff[4] <= 33'(req.vertex_b_y); v_ff[5] <= 33'(req.vertex_b_z);
         v_ff[6] <= 33'(req.vertex_c_x); v_ff[7] <= 33'(req.vertex_c_y);
         v_ff[8] <= 33'(req.vertex_c_z); last_ff <= req.last_triangle;
      end
      if (reset) begin
         st_ff <= ST_IDLE; k_ff <= '0; go_ff <= 1'b0; any_ff <= 1'b0;
         best_ff <= '1; hit_ok_ff <= 1'b0; rv_ff <= 1'b0;
         for (int i = 0; i < 3; i++) bp_ff[i] <= '0;
         for (int i = 0; i < 6; i++) s_ff[i] <= '0;
         ptol_ff <= ParTolReset; ttol_ff <= TTolReset;
      end else begin
         st_ff <= st_in; k_ff <= k_in; go_ff <= go_in; any_ff <= any_in;
         best_ff <= best_in; hit_ok_ff <= hit_ok_in; rv_ff <= rv_in;
         for (int i = 0; i < 3; i++) bp_ff[i] <= bp_in[i];
         if (csr.valid) begin
            unique case (csr.index)
               CSR_START_X: s_ff[0] <= 33'(signed'(csr.data[31:0]));
               CSR_START_Y: s_ff[1] <= 33'(signed'(csr.data[31:0]));
               CSR_START_Z: s_ff[2] <= 33'(signed'(csr.data[31:0]));
               CSR_END_X:   s_ff[3] <= 33'(signed'(csr.data[31:0]));
               CSR_END_Y:   s_ff[4] <= 33'(signed'(csr.data[31:0]));
               CSR_END_Z:   s_ff[5] <= 33'(signed'(csr.data[31:0]));
               CSR_PAR_TOL: ptol_ff <= csr.data;
               default:     ttol_ff <= csr.data[29:0];
            endcase
         end
      end
   end

   assign rsp.valid = rv_ff;
   assign rsp.hit_found = rhit_ff;
   assign rsp.hit_x = rx_ff;
   assign rsp.hit_y = ry_ff;
   assign rsp.hit_z = rz_ff;
endmodule

### rtl/stnh_chk.sv
// Port checker for the nearest-hit block, bound to the top level.
// The bind depends on the top level and its channel interfaces.
module stnh_chk (
   input logic clock,
   input logic reset,
   input logic req_valid, req_ready, rsp_valid, rsp_ready, rsp_hit_found,
   input logic [31:0] rsp_hit_x
);
   // A result beat holds until taken.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
   // No triangle is taken while a result waits.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("accepted during result");
   // A miss reports a zero point; only hit_x is checked here.
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit_found |-> rsp_hit_x == 32'd0) else $error("miss point");
   // After an accepted triangle the block is busy next cycle.
   a_seq: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("ready after accept");
endmodule

bind segment_triangle_nearest_hit stnh_chk u_chk (
   .clock, .reset, .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_hit_found(rsp.hit_found),
   .rsp_hit_x(rsp.hit_x));

### dv/segment_triangle_nearest_hit_tb.sv
`timescale 1ns / 100ps
// Testbench for segment_triangle_nearest_hit: streams triangles against a
// programmed segment and checks every nearest-hit beat against a predictor.
// Depends on stnh_pkg, the channel interfaces in stnh_if.sv and the RTL.

typedef logic signed [31:0] coord_set_type [9];

typedef struct {
   logic signed [31:0] v [9];
   bit last;
} tri_beat_type;

typedef struct {
   bit found;
   logic signed [31:0] x, y, z;
} hit_beat_type;

// Scoreboard: holds its own copy of the segment, tolerances and best hit.
class hit_scoreboard;
   localparam int TFrac = 30;
   stnh_pkg::wide_type seg_start [3];
   stnh_pkg::wide_type seg_end [3];
   logic [39:0] par_tol;
   logic [29:0] t_tol;
   bit found;
   logic [31:0] best_t;
   stnh_pkg::wide_type best_pt [3];
   hit_beat_type pending_hits [$];
   int errors;
   int sets_checked;
   int hits_checked;

   function new();
      for (int i = 0; i < 3; i++) begin
         seg_start[i] = 0;
         seg_end[i] = 0;
      end
      par_tol = stnh_pkg::ParTolReset;
      t_tol = stnh_pkg::TTolReset;
      clear_best();
   endfunction

   function void clear_best();
      found = 0;
      best_t = '1;
      for (int i = 0; i < 3; i++) best_pt[i] = 0;
   endfunction

   function void write_reg(logic [2:0] idx, logic [39:0] data);
      case (idx)
         stnh_pkg::CSR_START_X: seg_start[0] = $signed(data[31:0]);
         stnh_pkg::CSR_START_Y: seg_start[1] = $signed(data[31:0]);
         stnh_pkg::CSR_START_Z: seg_start[2] = $signed(data[31:0]);
         stnh_pkg::CSR_END_X:   seg_end[0] = $signed(data[31:0]);
         stnh_pkg::CSR_END_Y:   seg_end[1] = $signed(data[31:0]);
         stnh_pkg::CSR_END_Z:   seg_end[2] = $signed(data[31:0]);
         stnh_pkg::CSR_PAR_TOL: par_tol = data;
         stnh_pkg::CSR_T_TOL:   t_tol = data[29:0];
         default: ;
      endcase
   endfunction

   // Barycentric test on the rounded point, all in exact wide arithmetic.
   function bit in_triangle(stnh_pkg::wide_type a [3], stnh_pkg::wide_type b [3],
                            stnh_pkg::wide_type c [3], stnh_pkg::wide_type p [3]);
      stnh_pkg::wide_type d00, d01, d02, d11, d12, den, u, v;
      stnh_pkg::wide_type e0, e1, e2;
      d00 = 0; d01 = 0; d02 = 0; d11 = 0; d12 = 0;
      for (int i = 0; i < 3; i++) begin
         e0 = b[i] - a[i];
         e1 = c[i] - a[i];
         e2 = p[i] - a[i];
         d00 += e0 * e0;
         d01 += e0 * e1;
         d02 += e0 * e2;
         d11 += e1 * e1;
         d12 += e1 * e2;
      end
      den = d00 * d11 - d01 * d01;
      if (den <= 0) return 0;
      u = d11 * d02 - d01 * d12;
      v = d00 * d12 - d01 * d02;
      return (u >= 0) && (v >= 0) && !(den < u + v);
   endfunction

   // Intersect one triangle, keep the smallest t, queue a beat on the last one.
   function void note_triangle(tri_beat_type tb);
      stnh_pkg::wide_type a [3], b [3], c [3], dir [3], e0 [3], e1 [3], n [3];
      stnh_pkg::wide_type p [3];
      stnh_pkg::wide_type d, num, x, lo, hi, q, off, r, one, tt;
      logic [31:0] tq;
      hit_beat_type exp_hit;
      one = 1;
      for (int i = 0; i < 3; i++) begin
         a[i] = tb.v[i];
         b[i] = tb.v[3 + i];
         c[i] = tb.v[6 + i];
         dir[i] = seg_end[i] - seg_start[i];
         e0[i] = b[i] - a[i];
         e1[i] = c[i] - a[i];
      end
      n[0] = e0[1] * e1[2] - e0[2] * e1[1];
      n[1] = e0[2] * e1[0] - e0[0] * e1[2];
      n[2] = e0[0] * e1[1] - e0[1] * e1[0];
      d = 0;
      num = 0;
      for (int i = 0; i < 3; i++) begin
         d += dir[i] * n[i];
         num += (a[i] - seg_start[i]) * n[i];
      end
      if (d < 0) begin
         d = -d;
         num = -num;
      end
      if (d != 0 && !(d < $signed({216'd0, par_tol}))) begin
         tt = $signed({226'd0, t_tol});
         x = num <<< TFrac;
         lo = tt * d;
         hi = ((one <<< TFrac) + tt + one) * d;
         if (x >= lo && x < hi) begin
            q = x / d;
            tq = q[31:0];
            for (int i = 0; i < 3; i++) begin
               off = $signed({224'd0, tq}) * dir[i];
               r = (off + (one <<< (TFrac - 1))) >>> TFrac;
               p[i] = seg_start[i] + r;
               if (p[i] > 64'sd2147483647) p[i] = 64'sd2147483647;
               if (p[i] < -64'sd2147483648) p[i] = -64'sd2147483648;
            end
            if (in_triangle(a, b, c, p) && tq < best_t) begin
               found = 1;
               best_t = tq;
               for (int i = 0; i < 3; i++) best_pt[i] = p[i];
            end
         end
      end
      if (tb.last) begin
         exp_hit.found = found;
         exp_hit.x = found ? best_pt[0][31:0] : '0;
         exp_hit.y = found ? best_pt[1][31:0] : '0;
         exp_hit.z = found ? best_pt[2][31:0] : '0;
         pending_hits.push_back(exp_hit);
         clear_best();
      end
   endfunction

   function void check_hit(hit_beat_type got);
      hit_beat_type want;
      if (pending_hits.size() == 0) begin
         $display("%0t: unexpected result beat found=%0d (%0d,%0d,%0d)", $time,
                  got.found, got.x, got.y, got.z);
         errors++;
         return;
      end
      want = pending_hits.pop_front();
      sets_checked++;
      if (want.found) hits_checked++;
      if (got.found !== want.found) begin
         $display("%0t: hit_found expected %0d actual %0d", $time, want.found, got.found);
         errors++;
      end
      if (got.x !== want.x) begin
         $display("%0t: hit_x expected %0d actual %0d", $time, want.x, got.x);
         errors++;
      end
      if (got.y !== want.y) begin
         $display("%0t: hit_y expected %0d actual %0d", $time, want.y, got.y);
         errors++;
      end
      if (got.z !== want.z) begin
         $display("%0t: hit_z expected %0d actual %0d", $time, want.z, got.z);
         errors++;
      end
   endfunction
endclass

module segment_triangle_nearest_hit_tb;
   import stnh_pkg::*;

   localparam int WatchdogLimit = 40000;
   localparam int SettleCycles = 2500;
   localparam int RandomItems = 680;

   logic clock;
   logic reset;

   stnh_req_if req_if ();
   stnh_rsp_if rsp_if ();
   stnh_csr_if csr_if ();

   segment_triangle_nearest_hit u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if),
      .csr   (csr_if)
   );

   hit_scoreboard sb = new();

   bit quiet;          // no new stall bursts or sender gaps in the closing stretch
   bit gaps_on;        // sender gaps allowed in this phase
   int stall_left;
   int idle_cycles;
   int triangles_sent;
   longint seg_s [3];
   longint seg_e [3];

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // Receiver readiness: random stall bursts, none begun in the closing stretch.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 10);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      hit_beat_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.found = rsp_if.hit_found;
         got.x = rsp_if.hit_x;
         got.y = rsp_if.hit_y;
         got.z = rsp_if.hit_z;
         sb.check_hit(got);
      end
   end

   // Watchdog on cycles in which no beat moves on any channel.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || (csr_if.valid && csr_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("%0t: no progress for %0d cycles", $time, idle_cycles);
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // One register write; valid drops for a cycle before the next beat.
   task automatic write_csr(logic [2:0] idx, logic [39:0] data);
      csr_if.index <= idx;
      csr_if.data <= data;
      csr_if.valid <= 1'b1;
      do @(posedge clock); while (!csr_if.ready);
      sb.write_reg(idx, data);
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_segment(longint s [3], longint e [3]);
      for (int i = 0; i < 3; i++) begin
         seg_s[i] = s[i];
         seg_e[i] = e[i];
         write_csr(3'(CSR_START_X + i), 40'(s[i]));
         write_csr(3'(CSR_END_X + i), 40'(e[i]));
      end
   endtask

   task automatic set_tolerances(logic [39:0] par, logic [29:0] tt);
      write_csr(CSR_PAR_TOL, par);
      write_csr(CSR_T_TOL, {10'd0, tt});
   endtask

   // Wait until every expected beat is back and the block has settled.
   task automatic drain();
      req_if.valid <= 1'b0;
      while (sb.pending_hits.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic send_triangle(tri_beat_type tb);
      int gap;
      if (gaps_on && !quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 11);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.vertex_a_x <= tb.v[0];
      req_if.vertex_a_y <= tb.v[1];
      req_if.vertex_a_z <= tb.v[2];
      req_if.vertex_b_x <= tb.v[3];
      req_if.vertex_b_y <= tb.v[4];
      req_if.vertex_b_z <= tb.v[5];
      req_if.vertex_c_x <= tb.v[6];
      req_if.vertex_c_y <= tb.v[7];
      req_if.vertex_c_z <= tb.v[8];
      req_if.last_triangle <= tb.last;
      req_if.valid <= 1'b1;
      do @(posedge clock); while (!req_if.ready);
      sb.note_triangle(tb);
      triangles_sent++;
   endtask

   // Triangle given in whole units, scaled to Q16.16.
   task automatic send_units(int c [9], bit last);
      tri_beat_type tb;
      for (int i = 0; i < 9; i++) tb.v[i] = c[i] * 65536;
      tb.last = last;
      send_triangle(tb);
   endtask

   task automatic send_raw(coord_set_type c, bit last);
      tri_beat_type tb;
      tb.v = c;
      tb.last = last;
      send_triangle(tb);
   endtask

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic longint rand_around(longint mag);
      return longint'($urandom_range(0, 2 * mag)) - mag;
   endfunction

   // Triangle scattered around a point on (or just past) the segment.
   function automatic tri_beat_type aimed_triangle(bit last);
      tri_beat_type tb;
      longint t, p [3], radius;
      t = $urandom_range(0, (1 << 30) + (1 << 27));
      radius = longint'(1) << $urandom_range(2, 26);
      for (int i = 0; i < 3; i++)
         p[i] = seg_s[i] + (((t >>> 10) * (seg_e[i] - seg_s[i])) >>> 20);
      for (int k = 0; k < 3; k++)
         for (int i = 0; i < 3; i++)
            tb.v[3 * k + i] = clamp32(p[i] + rand_around(radius));
      tb.last = last;
      return tb;
   endfunction

   function automatic tri_beat_type noise_triangle(bit last);
      tri_beat_type tb;
      for (int i = 0; i < 9; i++) tb.v[i] = $urandom;
      tb.last = last;
      return tb;
   endfunction

   function automatic longint pick_coord();
      case ($urandom_range(0, 4))
         0: return longint'($signed(32'($urandom)));
         1: return $urandom_range(0, 1) ? 64'sd2147483647 : -64'sd2147483648;
         default: return rand_around(longint'(1) << $urandom_range(8, 26));
      endcase
   endfunction

   task automatic random_settings();
      longint s [3], e [3];
      logic [39:0] par;
      logic [29:0] tt;
      for (int i = 0; i < 3; i++) begin
         s[i] = pick_coord();
         e[i] = pick_coord();
      end
      case ($urandom_range(0, 5))
         0: par = '0;
         1: par = '1;
         2: par = {$urandom, 8'($urandom)};
         3: par = 40'($urandom_range(0, 1 << 20));
         default: par = ParTolReset;
      endcase
      case ($urandom_range(0, 5))
         0: tt = '0;
         1: tt = '1;
         2: tt = 30'($urandom);
         default: tt = TTolReset;
      endcase
      set_segment(s, e);
      set_tolerances(par, tt);
   endtask

   initial begin
      int set_left;
      int phase_items;
      tri_beat_type tb;
      reset = 1'b1;
      quiet = 1'b0;
      gaps_on = 1'b1;
      stall_left = 0;
      idle_cycles = 0;
      triangles_sent = 0;
      rsp_if.ready = 1'b0;
      req_if.valid = 1'b0;
      req_if.vertex_a_x = '0; req_if.vertex_a_y = '0; req_if.vertex_a_z = '0;
      req_if.vertex_b_x = '0; req_if.vertex_b_y = '0; req_if.vertex_b_z = '0;
      req_if.vertex_c_x = '0; req_if.vertex_c_y = '0; req_if.vertex_c_z = '0;
      req_if.last_triangle = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = '0;
      csr_if.data = '0;
      for (int i = 0; i < 3; i++) begin
         seg_s[i] = 0;
         seg_e[i] = 0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Directed: segment along x from 0 to 10 with the reset tolerances.
      set_segment('{0, 0, 0}, '{10 * 65536, 0, 0});
      set_tolerances(ParTolReset, TTolReset);
      send_units('{5, -1, -1, 5, 3, -1, 5, -1, 3}, 0);
      send_units('{3, -1, -1, 3, 3, -1, 3, -1, 3}, 0);   // nearer hit
      send_units('{3, -2, -2, 3, 4, -2, 3, -2, 4}, 0);   // same t: earlier one kept
      send_units('{7, -1, -1, 7, 3, -1, 7, -1, 3}, 1);
      send_units('{5, 0, 0, 6, 1, 1, 7, 2, 2}, 0);       // degenerate
      send_units('{0, 0, -1, 10, 0, -1, 0, 0, 3}, 0);    // contains the direction
      send_units('{5, 1, 1, 5, 3, 1, 5, 1, 3}, 0);       // plane hit, point outside
      send_units('{-1, -1, -1, -1, 3, -1, -1, -1, 3}, 0); // behind the start
      send_units('{11, -1, -1, 11, 3, -1, 11, -1, 3}, 1); // past the end
      send_units('{0, -1, -1, 0, 3, -1, 0, -1, 3}, 1);    // t of zero, below tolerance
      send_units('{10, -1, -1, 10, 3, -1, 10, -1, 3}, 1); // t of one
      send_units('{5, 0, 0, 5, 2, 0, 5, 0, 2}, 1);        // through a vertex
      send_raw('{9{32'sh80000000}}, 0);
      send_raw('{9{32'sh7FFFFFFF}}, 0);
      send_raw('{32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
                 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000,
                 32'sh7FFFFFFF}, 1);
      drain();

      // Zero tolerances: zero dot is still skipped, t of zero now counts.
      set_tolerances('0, '0);
      send_units('{0, 0, -1, 10, 0, -1, 0, 0, 3}, 1);
      send_units('{0, -1, -1, 0, 3, -1, 0, -1, 3}, 1);
      drain();

      // Largest tolerances near the top of the range: hit point saturates.
      set_segment('{64'sh7F000000, 0, 0}, '{64'sh7FFFFFFF, 0, 0});
      set_tolerances('1, '1);
      send_raw('{32'sh7FFFFFFF, -32'sh00100000, 32'sh00100000, 32'sh7FFFFFFF,
                 32'sh00100000, 32'sh00100000, 32'sh7F000000, 0, 32'sh00300000}, 1);
      send_units('{-1, -1, -1, -1, 3, -1, -1, -1, 3}, 1);
      drain();

      // Random phases: mostly aimed triangles in short sets, some noise.
      phase_items = 0;
      set_left = 0;
      random_settings();
      for (int n = 0; n < RandomItems; n++) begin
         if (n >= RandomItems - 100) quiet = 1'b1;
         if (set_left == 0) set_left = $urandom_range(1, 6);
         set_left--;
         if ($urandom_range(0, 9) < 8) tb = aimed_triangle(set_left == 0);
         else tb = noise_triangle(set_left == 0);
         send_triangle(tb);
         phase_items++;
         if (set_left == 0 && phase_items >= 80 && n < RandomItems - 100) begin
            drain();
            random_settings();
            gaps_on = $urandom_range(0, 3) != 0;
            phase_items = 0;
         end
      end
      if (set_left != 0) begin
         tb = aimed_triangle(1'b1);
         send_triangle(tb);
      end
      req_if.valid <= 1'b0;
      while (sb.pending_hits.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);

      if (sb.pending_hits.size() != 0) begin
         $display("%0t: %0d result beats never arrived", $time, sb.pending_hits.size());
         sb.errors++;
      end
      $display("Ran %0d triangles over several segment and tolerance settings.",
               triangles_sent);
      $display("Checked %0d set results, %0d of them hits; %0d mismatches.",
               sb.sets_checked, sb.hits_checked, sb.errors);
      if (sb.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/stnh_pkg.sv
rtl/stnh_if.sv
rtl/stnh_mul.sv
rtl/stnh_seq.sv
rtl/segment_triangle_nearest_hit.sv
rtl/stnh_chk.sv
dv/segment_triangle_nearest_hit_tb.sv
